### rtl/core/spq_pkg.sv
// Package for the sorted-array priority queue.
// Holds operation and status codes and the cell control struct.
// No dependencies.
package spq_pkg;

	// Operation codes of the request func field
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Status codes of a response
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Shift control broadcast to every cell of the row
	typedef struct packed {
		logic ins_en;  // place the new value, shift entries not smaller back
		logic rem_en;  // pop the front, shift every entry forward
	} cell_ctrl_t;

endpackage

### rtl/core/spq_ifs.sv
// Valid/ready channel interfaces for the sorted-array priority queue.
// spq_req_if carries requests, spq_rsp_if carries results.
// No dependencies.
interface spq_req_if #(
	parameter int VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, func, value, input ready);
	modport sink   (input valid, func, value, output ready);
endinterface

interface spq_rsp_if #(
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 4
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic signed [VALUE_BITS-1:0] removed_value;
	logic signed [VALUE_BITS-1:0] front_value;
	logic [COUNT_BITS-1:0]        entry_count;
	logic                         is_empty;
	logic                         is_full;

	modport source (output valid, status, removed_value, front_value, entry_count,
		is_empty, is_full, input ready);
	modport sink   (input valid, status, removed_value, front_value, entry_count,
		is_empty, is_full, output ready);
endinterface

### rtl/core/spq_cell.sv
// One storage cell of the sorted row.
// Depends on spq_pkg for the cell control struct.
module spq_cell #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  spq_pkg::cell_ctrl_t          ctrl,
	input  logic signed [VALUE_BITS-1:0] new_value,
	input  logic                         occupied,
	input  logic                         prev_lt,
	input  logic signed [VALUE_BITS-1:0] prev_value,
	input  logic signed [VALUE_BITS-1:0] next_value,
	output logic                         lt,
	output logic signed [VALUE_BITS-1:0] value_q,
	output logic signed [VALUE_BITS-1:0] value_d
);
	import spq_pkg::*;

	// Stored entry is occupied and strictly smaller than the incoming value
	assign lt = occupied && (value_q < new_value);

	// Next entry: keep, take the new value, or shift from a neighbor
	always_comb begin
		value_d = value_q;
		if (ctrl.ins_en) begin
			if (!lt) begin
				value_d = prev_lt ? new_value : prev_value;
			end
		end else if (ctrl.rem_en) begin
			value_d = next_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

### rtl/core/sorted_array_priority_queue.sv
// Top level of the sorted-array min-priority queue.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_cell.
//
// Bounded min-priority queue of DEPTH signed entries kept in ascending order
// in a row of cells, front (smallest) at cell 0. An insert places the value
// ahead of all entries not smaller than it, so among equal values the newest
// leaves first; a remove pops the front. Each request gives one response with
// status, popped value, new front, count and empty/full flags. Insert into a
// full queue returns status 1 and remove from an empty queue returns status 2,
// both without changing the contents. Throughput is one transaction per
// cycle while responses are taken: every cell compares its entry against the
// incoming value in the same cycle and shifts at most one place, and the
// response is registered, so it appears in the cycle after the request is
// accepted. A waiting response only stalls requests while it is not taken.
module sorted_array_priority_queue #(
	parameter int DEPTH      = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int COUNT_BITS = $clog2(DEPTH + 1);

	logic [COUNT_BITS-1:0]        count_q;
	logic [COUNT_BITS-1:0]        count_d;
	logic                         rsp_valid_q;
	logic [1:0]                   status_q;
	logic signed [VALUE_BITS-1:0] removed_q;
	logic signed [VALUE_BITS-1:0] front_q;
	logic [COUNT_BITS-1:0]        count_out_q;
	logic                         empty_q;
	logic                         full_q;

	logic                         accept;
	logic                         is_full_now;
	logic                         is_empty_now;
	logic [1:0]                   status_d;
	cell_ctrl_t                   ctrl;

	logic                         cell_lt  [DEPTH];
	logic signed [VALUE_BITS-1:0] cell_val [DEPTH];
	logic signed [VALUE_BITS-1:0] cell_nxt [DEPTH];

	// Handshake: take a request whenever the response register is free
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// Operation decode
	assign is_full_now  = (count_q == COUNT_BITS'(DEPTH));
	assign is_empty_now = (count_q == '0);

	always_comb begin
		ctrl     = '0;
		status_d = ST_OK;
		count_d  = count_q;
		case (req.func)
			OP_INSERT: begin
				if (is_full_now) begin
					status_d = ST_FULL;
				end else begin
					ctrl.ins_en = accept;
					count_d     = count_q + COUNT_BITS'(1);
				end
			end
			OP_REMOVE: begin
				if (is_empty_now) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.rem_en = accept;
					count_d     = count_q - COUNT_BITS'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Row of cells, each linked to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                         prev_lt_w;
		logic signed [VALUE_BITS-1:0] prev_val_w;
		logic signed [VALUE_BITS-1:0] next_val_w;

		if (i == 0) begin : g_head
			assign prev_lt_w  = 1'b1;
			assign prev_val_w = req.value;
		end else begin : g_body
			assign prev_lt_w  = cell_lt[i-1];
			assign prev_val_w = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_val_w = cell_val[i];
		end else begin : g_mid
			assign next_val_w = cell_val[i+1];
		end

		spq_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.new_value (req.value),
			.occupied  (COUNT_BITS'(i) < count_q),
			.prev_lt   (prev_lt_w),
			.prev_value(prev_val_w),
			.next_value(next_val_w),
			.lt        (cell_lt[i]),
			.value_q   (cell_val[i]),
			.value_d   (cell_nxt[i])
		);
	end

	// Occupancy and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			removed_q   <= ctrl.rem_en ? cell_val[0] : '0;
			front_q     <= (count_d != '0) ? cell_nxt[0] : '0;
			count_out_q <= count_d;
			empty_q     <= (count_d == '0);
			full_q      <= (count_d == COUNT_BITS'(DEPTH));
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_q;
	assign rsp.front_value   = front_q;
	assign rsp.entry_count   = count_out_q;
	assign rsp.is_empty      = empty_q;
	assign rsp.is_full       = full_q;

endmodule
